// ===== sv/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the circular list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INS_TAIL = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_FIRST    = 3'd2,
        OP_NEXT     = 3'd3,
        OP_REMOVE   = 3'd4
    } t_op;

endpackage

`default_nettype wire

// ===== sv/circular_list_engine.sv =====
// ----------------------------------------------------------------------------
// circular_list_engine
// Circular singly linked list with tail, cursor and prior node over a pool.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// on o_ok, o_item and o_count for exactly one cycle with o_valid high, and
// must be captured then. A refused command returns its result in the next
// cycle and leaves busy low. Remove runs in S_LOAD; first and next in
// S_LOAD, S_DATA (a link read, then a dependent data read); insert in
// S_LOAD into an empty list, else S_LOAD, S_LINK (two writes through the
// single link memory port). Busy is low in the cycle the result is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_engine
    import cle_pkg::*;
#(
    parameter int NODES = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OP_W-1:0]          i_op,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_valid,
    output logic                          o_ok,
    output logic signed [DATA_W-1:0]      o_item,
    output logic [$clog2(NODES+1)-1:0]    o_count
);

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_LINK,
        S_DATA
    } t_state;

    t_state                   r_state;
    t_op                      r_op;
    logic signed [DATA_W-1:0] r_value;
    logic [IW-1:0]            r_tail;
    logic [IW-1:0]            r_cursor;
    logic [IW-1:0]            r_prior;
    logic [IW-1:0]            r_new;
    logic [CW-1:0]            r_count;
    logic                     r_cur_valid;
    logic [CW-1:0]            r_fsp;
    logic [CW-1:0]            r_fresh;
    logic [IW-1:0]            r_stack_rd;
    logic                     r_valid;
    logic                     r_ok;
    logic signed [DATA_W-1:0] r_item;
    logic [CW-1:0]            r_cnt_out;

    logic [IW-1:0] free_mem [NODES];

    logic                     accept;
    t_op                      op_in;
    logic                     full;
    logic                     empty;
    logic                     go_ok;
    logic [CW-1:0]            fsp_dec;
    logic [CW-1:0]            n_count_inc;
    logic [CW-1:0]            n_count_dec;
    logic [IW-1:0]            alloc_idx;
    logic                     data_we;
    logic [IW-1:0]            data_waddr;
    logic signed [DATA_W-1:0] data_wdata;
    logic [IW-1:0]            data_raddr;
    logic signed [DATA_W-1:0] data_rd;
    logic                     link_we;
    logic [IW-1:0]            link_waddr;
    logic [IW-1:0]            link_wdata;
    logic [IW-1:0]            link_raddr;
    logic [IW-1:0]            link_rd;
    logic                     stk_we;
    logic [IW-1:0]            stk_waddr;
    logic [IW-1:0]            stk_raddr;

    cle_pool #(
        .NODES (NODES),
        .IW    (IW)
    ) u_pool (
        .i_clk        (i_clk),
        .i_data_we    (data_we),
        .i_data_waddr (data_waddr),
        .i_data_wdata (data_wdata),
        .i_data_raddr (data_raddr),
        .o_data_rdata (data_rd),
        .i_link_we    (link_we),
        .i_link_waddr (link_waddr),
        .i_link_wdata (link_wdata),
        .i_link_raddr (link_raddr),
        .o_link_rdata (link_rd)
    );

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            free_mem[stk_waddr] <= r_cursor;
        end
        r_stack_rd <= free_mem[stk_raddr];
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_ok    = r_ok;
    assign o_item  = r_item;
    assign o_count = r_cnt_out;

    always_comb begin
        accept      = start && !busy;
        op_in       = t_op'(i_op);
        full        = (r_count == CW'(NODES));
        empty       = (r_count == '0);
        fsp_dec     = r_fsp - CW'(1);
        n_count_inc = r_count + CW'(1);
        n_count_dec = r_count - CW'(1);
        alloc_idx   = (r_fsp != '0) ? r_stack_rd : r_fresh[IW-1:0];

        case (op_in)
            OP_INS_TAIL, OP_INS_HEAD: go_ok = !full;
            OP_FIRST:                 go_ok = !empty;
            OP_NEXT:                  go_ok = !empty && r_cur_valid;
            OP_REMOVE: go_ok = !empty && r_cur_valid &&
                               !((r_count > CW'(1)) && (r_prior == r_cursor));
            default:                  go_ok = 1'b0;
        endcase

        data_we    = 1'b0;
        data_waddr = alloc_idx;
        data_wdata = r_value;
        data_raddr = r_cursor;
        link_we    = 1'b0;
        link_waddr = alloc_idx;
        link_wdata = link_rd;
        link_raddr = r_cursor;
        stk_we     = 1'b0;
        stk_waddr  = r_fsp[IW-1:0];
        stk_raddr  = fsp_dec[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (!(op_in inside {OP_NEXT, OP_REMOVE})) begin
                    link_raddr = r_tail;
                end
            end
            S_LOAD: begin
                case (r_op)
                    OP_INS_TAIL, OP_INS_HEAD: begin
                        data_we    = 1'b1;
                        link_we    = 1'b1;
                        link_wdata = empty ? alloc_idx : link_rd;
                    end
                    OP_FIRST, OP_NEXT: begin
                        data_raddr = link_rd;
                    end
                    OP_REMOVE: begin
                        link_we    = (r_count != CW'(1));
                        link_waddr = r_prior;
                        stk_we     = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_tail;
                link_wdata = r_new;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_tail      <= '0;
            r_cursor    <= '0;
            r_prior     <= '0;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_fsp       <= '0;
            r_fresh     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= op_in;
                        r_value <= i_value;
                        if (go_ok) begin
                            r_state <= S_LOAD;
                            if (op_in == OP_FIRST) begin
                                r_prior <= r_tail;
                            end
                            if (op_in == OP_NEXT) begin
                                r_prior <= r_cursor;
                            end
                        end else begin
                            r_valid   <= 1'b1;
                            r_ok      <= 1'b0;
                            r_item    <= '0;
                            r_cnt_out <= r_count;
                        end
                    end
                end
                S_LOAD: begin
                    case (r_op)
                        OP_INS_TAIL, OP_INS_HEAD: begin
                            if (r_fsp != '0) begin
                                r_fsp <= fsp_dec;
                            end else begin
                                r_fresh <= r_fresh + CW'(1);
                            end
                            if (empty) begin
                                r_tail    <= alloc_idx;
                                r_count   <= n_count_inc;
                                r_valid   <= 1'b1;
                                r_ok      <= 1'b1;
                                r_item    <= '0;
                                r_cnt_out <= n_count_inc;
                                r_state   <= S_IDLE;
                            end else begin
                                if (r_cur_valid && (r_prior == r_tail) &&
                                    ((r_prior != r_cursor) || (r_count == CW'(1)))) begin
                                    r_prior <= alloc_idx;
                                end
                                r_new   <= alloc_idx;
                                r_state <= S_LINK;
                            end
                        end
                        OP_FIRST, OP_NEXT: begin
                            r_cursor    <= link_rd;
                            r_cur_valid <= 1'b1;
                            r_state     <= S_DATA;
                        end
                        OP_REMOVE: begin
                            if (r_count == CW'(1)) begin
                                r_cur_valid <= 1'b0;
                                r_tail      <= '0;
                                r_cursor    <= '0;
                                r_prior     <= '0;
                            end else begin
                                if (r_cursor == r_tail) begin
                                    r_tail <= r_prior;
                                end
                                r_cursor <= r_prior;
                            end
                            r_fsp     <= r_fsp + CW'(1);
                            r_count   <= n_count_dec;
                            r_valid   <= 1'b1;
                            r_ok      <= 1'b1;
                            r_item    <= data_rd;
                            r_cnt_out <= n_count_dec;
                            r_state   <= S_IDLE;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_LINK: begin
                    if (r_op == OP_INS_TAIL) begin
                        r_tail <= r_new;
                    end
                    r_count   <= n_count_inc;
                    r_valid   <= 1'b1;
                    r_ok      <= 1'b1;
                    r_item    <= '0;
                    r_cnt_out <= n_count_inc;
                    r_state   <= S_IDLE;
                end
                S_DATA: begin
                    r_valid   <= 1'b1;
                    r_ok      <= 1'b1;
                    r_item    <= data_rd;
                    r_cnt_out <= r_count;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/cle_pool.sv =====
// ----------------------------------------------------------------------------
// cle_pool
// Node pool: data and link memories, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_pool
    import cle_pkg::*;
#(
    parameter int NODES = 16,
    parameter int IW    = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_data_we,
    input  wire logic [IW-1:0]            i_data_waddr,
    input  wire logic signed [DATA_W-1:0] i_data_wdata,
    input  wire logic [IW-1:0]            i_data_raddr,
    output logic signed [DATA_W-1:0]      o_data_rdata,
    input  wire logic                     i_link_we,
    input  wire logic [IW-1:0]            i_link_waddr,
    input  wire logic [IW-1:0]            i_link_wdata,
    input  wire logic [IW-1:0]            i_link_raddr,
    output logic [IW-1:0]                 o_link_rdata
);

    logic signed [DATA_W-1:0] data_mem [NODES];
    logic [IW-1:0]            link_mem [NODES];

    always_ff @(posedge i_clk) begin
        if (i_data_we) begin
            data_mem[i_data_waddr] <= i_data_wdata;
        end
        o_data_rdata <= data_mem[i_data_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            link_mem[i_link_waddr] <= i_link_wdata;
        end
        o_link_rdata <= link_mem[i_link_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/cle_checker.sv =====
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the circular list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_checker
    import cle_pkg::*;
#(
    parameter int NODES = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic                          o_ok,
    input wire logic signed [DATA_W-1:0]      o_item,
    input wire logic [$clog2(NODES+1)-1:0]    o_count
);

    localparam int CW = $clog2(NODES + 1);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("beat shown right after reset");

    a_accept_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted command neither busy nor answered");

    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_item == '0))
        else $error("refused beat carries nonzero item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CW'(NODES)))
        else $error("node count beyond pool size");

endmodule

bind circular_list_engine cle_checker #(
    .NODES (NODES)
) u_cle_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_ok    (o_ok),
    .o_item  (o_item),
    .o_count (o_count)
);

`default_nettype wire
